// ===== design/rbfp_pkg.sv =====
// Shared constants, result type and event decoding for the response box frame parser.
package rbfp_pkg;

   localparam logic [7:0] LEAD_CLOCK     = 8'd89;
   localparam logic [7:0] LEAD_MODE      = 8'd69;
   localparam logic [7:0] LEAD_SINGLE    = 8'd101;
   localparam logic [7:0] CODE_LIGHT     = 8'd48;
   localparam logic [7:0] CODE_SOUND     = 8'd97;
   localparam logic [7:0] CODE_AUX       = 8'd98;
   localparam logic [7:0] CODE_TIME      = 8'd57;
   localparam logic [7:0] CODE_ASCII_ONE = 8'd49;
   localparam logic [7:0] CODE_ASCII_END = 8'd56;
   localparam logic [7:0] CODE_RAW_LAST  = 8'd7;

   localparam logic [7:0] MODE_RESET = 8'd63;

   localparam logic [2:0] POS_IDLE = 3'd0;
   localparam logic [2:0] POS_LEAD = 3'd1;
   localparam logic [2:0] POS_FIRST_LAST = 3'd3;
   localparam logic [2:0] POS_FRAME_LAST = 3'd6;

   localparam logic [2:0] KIND_CLOCK  = 3'd0;
   localparam logic [2:0] KIND_BUTTON = 3'd1;
   localparam logic [2:0] KIND_LIGHT  = 3'd2;
   localparam logic [2:0] KIND_SOUND  = 3'd3;
   localparam logic [2:0] KIND_AUX    = 3'd4;
   localparam logic [2:0] KIND_TIME   = 3'd5;
   localparam logic [2:0] KIND_RESEND = 3'd6;

   typedef struct packed {
      logic [2:0]  result_kind;
      logic [1:0]  button_number;
      logic        button_level;
      logic [23:0] stamp_first;
      logic [23:0] stamp_second;
      logic [7:0]  resend_mode;
   } result_type;

   typedef struct packed {
      logic       known;
      logic [2:0] kind;
      logic [1:0] button_number;
      logic       button_level;
   } event_type;

   // Decode the lead byte of a completed seven-byte frame.
   function automatic event_type classify(input logic [7:0] lead);
      event_type  ev;
      logic [7:0] code;
      ev   = '0;
      code = lead;
      if (lead >= CODE_ASCII_ONE && lead <= CODE_ASCII_END) begin
         code = lead - CODE_ASCII_ONE;
      end
      if (lead == LEAD_CLOCK) begin
         ev.known = 1'b1;
         ev.kind  = KIND_CLOCK;
      end else if (code <= CODE_RAW_LAST) begin
         ev.known         = 1'b1;
         ev.kind          = KIND_BUTTON;
         ev.button_number = code[2:1];
         ev.button_level  = ~code[0];
      end else if (code == CODE_LIGHT) begin
         ev.known = 1'b1;
         ev.kind  = KIND_LIGHT;
      end else if (code == CODE_SOUND) begin
         ev.known = 1'b1;
         ev.kind  = KIND_SOUND;
      end else if (code == CODE_AUX) begin
         ev.known = 1'b1;
         ev.kind  = KIND_AUX;
      end else if (code == CODE_TIME) begin
         ev.known = 1'b1;
         ev.kind  = KIND_TIME;
      end
      return ev;
   endfunction

endpackage

// ===== design/response_box_frame_parser_core.sv =====
// Top level of the response box frame parser: byte framing, event decode and output buffer.
//
// Bytes arrive one per transaction and are parsed at one byte per cycle while req_stall
// is low: each accepted byte passes through a single stage of position counter, stamp
// shift and lead-code decode into the result register, or into the skid register when a
// stalled result holds the result register. Lead 101 is a one-byte frame, lead 69 a
// two-byte mode report that yields a resend request when the mode byte differs from
// csr_write_data last written (reset 63), and any other lead a seven-byte frame whose two
// 24-bit big-endian stamps come with the event. Unknown codes and matching modes give no
// result. A two-entry output buffer (result register plus skid register) keeps input
// flowing while a result waits; req_stall is raised only while both entries are full.
module response_box_frame_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_kind,
   output logic [1:0]  rsp_button_number,
   output logic        rsp_button_level,
   output logic [23:0] rsp_stamp_first,
   output logic [23:0] rsp_stamp_second,
   output logic [7:0]  rsp_resend_mode,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);

   logic [7:0]  mode_ff, mode_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  lead_ff, lead_in;
   logic [23:0] first_ff, first_in;
   logic [23:0] second_ff, second_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rbfp_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                skid_valid_ff, skid_valid_in;
   rbfp_pkg::result_type skid_data_ff, skid_data_in;

   logic                 req_accept;
   logic                 rsp_take;
   logic                 new_valid;
   rbfp_pkg::result_type new_data;
   rbfp_pkg::event_type  ev;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   assign ev = rbfp_pkg::classify(lead_ff);

   // Framing and decode for one byte
   always_comb begin
      mode_in   = csr_write_enable ? csr_write_data : mode_ff;
      pos_in    = pos_ff;
      lead_in   = lead_ff;
      first_in  = first_ff;
      second_in = second_ff;
      new_valid = 1'b0;
      new_data  = '0;
      if (req_accept) begin
         if (pos_ff == rbfp_pkg::POS_IDLE) begin
            lead_in   = req_rx_byte;
            first_in  = '0;
            second_in = '0;
            pos_in    = (req_rx_byte != rbfp_pkg::LEAD_SINGLE) ? rbfp_pkg::POS_LEAD
                                                               : rbfp_pkg::POS_IDLE;
         end else if (lead_ff == rbfp_pkg::LEAD_MODE) begin
            pos_in = rbfp_pkg::POS_IDLE;
            if (req_rx_byte != mode_ff) begin
               new_valid            = 1'b1;
               new_data.result_kind = rbfp_pkg::KIND_RESEND;
               new_data.resend_mode = mode_ff;
            end
         end else begin
            if (pos_ff <= rbfp_pkg::POS_FIRST_LAST) begin
               first_in = {first_ff[15:0], req_rx_byte};
            end else begin
               second_in = {second_ff[15:0], req_rx_byte};
            end
            if (pos_ff == rbfp_pkg::POS_FRAME_LAST) begin
               pos_in                 = rbfp_pkg::POS_IDLE;
               new_valid              = ev.known;
               new_data.result_kind   = ev.kind;
               new_data.button_number = ev.button_number;
               new_data.button_level  = ev.button_level;
               new_data.stamp_first   = first_in;
               new_data.stamp_second  = second_in;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
      end
   end

   // Output buffer: result register with a skid entry behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_take && skid_valid_ff) begin
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else if (new_valid && (!rsp_valid_ff || rsp_take)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = new_data;
      end else if (new_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = new_data;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= rbfp_pkg::MODE_RESET;
         pos_ff        <= rbfp_pkg::POS_IDLE;
         lead_ff       <= '0;
         first_ff      <= '0;
         second_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         lead_ff       <= lead_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = rsp_data_ff.result_kind;
   assign rsp_button_number = rsp_data_ff.button_number;
   assign rsp_button_level  = rsp_data_ff.button_level;
   assign rsp_stamp_first   = rsp_data_ff.stamp_first;
   assign rsp_stamp_second  = rsp_data_ff.stamp_second;
   assign rsp_resend_mode   = rsp_data_ff.resend_mode;

   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while result register empty");

   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid entry filled without a stalled result");

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff <= rbfp_pkg::POS_FRAME_LAST)
      else $error("byte position beyond frame end");

   a_mode_frame_short : assert property (@(posedge clock) disable iff (reset)
      (pos_ff != rbfp_pkg::POS_IDLE && lead_ff == rbfp_pkg::LEAD_MODE)
         |-> pos_ff == rbfp_pkg::POS_LEAD)
      else $error("mode report frame longer than two bytes");

endmodule
